// ===== rtl/pts_pkg.sv =====
// shared types, constants and span bookkeeping functions for the word splitter
package pts_pkg;

	// prompt length limit, positions saturate here
	localparam int MAX_LEN = 4096;
	// at most this many spans come out of one byte
	localparam int MAX_RES = 4;
	// depth of the queue between front and back
	localparam int QDEPTH  = 4;

	localparam int POS_W     = $clog2(MAX_LEN + 2);
	localparam int ORG_W     = $clog2(MAX_LEN);
	localparam int CNT_W     = $clog2(MAX_RES + 1);
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// port widths fixed by the interface
	localparam int BYTE_W        = 8;
	localparam int SPAN_START_W  = 12;
	localparam int SPAN_LENGTH_W = 13;

	localparam int DIGIT_CHUNK = 3;

	localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_S     = 8'h73;
	localparam logic [BYTE_W-1:0] CH_T     = 8'h74;
	localparam logic [BYTE_W-1:0] CH_M     = 8'h6D;
	localparam logic [BYTE_W-1:0] CH_D     = 8'h64;
	localparam logic [BYTE_W-1:0] CH_R     = 8'h72;
	localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
	localparam logic [BYTE_W-1:0] CH_V     = 8'h76;
	localparam logic [BYTE_W-1:0] CH_L     = 8'h6C;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_PREFIX,
		MODE_LETTER,
		MODE_DIGIT,
		MODE_PUNCT,
		MODE_APOS,
		MODE_APOS2
	} mode_t;

	// working copy of the splitter state while one byte is processed
	typedef struct packed {
		mode_t                             mode;
		logic [ORG_W-1:0]                  origin;
		logic                              ois;
		logic [BYTE_W-1:0]                 held;
		logic [CNT_W-1:0]                  cnt;
		logic [MAX_RES-1:0][ORG_W-1:0]     start;
		logic [MAX_RES-1:0][POS_W-1:0]     len;
	} walk_t;

	// spans produced by one byte, handed from front to back
	typedef struct packed {
		logic [MAX_RES-1:0][ORG_W-1:0]     start;
		logic [MAX_RES-1:0][POS_W-1:0]     len;
		logic [RES_IDX_W-1:0]              last_idx;
		logic                              is_last;
		logic                              overflow;
	} rec_t;

	function automatic logic f_is_letter(input logic [BYTE_W-1:0] c);
		logic r;
		case (c) inside
			[8'h41:8'h5A], [8'h61:8'h7A]: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic f_is_digit(input logic [BYTE_W-1:0] c);
		logic r;
		case (c) inside
			[8'h30:8'h39]: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// ! . , ? / \ * - # lf cr tab : ; = %
	function automatic logic f_is_punct(input logic [BYTE_W-1:0] c);
		logic r;
		case (c) inside
			8'h21, 8'h2E, 8'h2C, 8'h3F, 8'h2F, 8'h5C, 8'h2A, 8'h2D,
			8'h23, 8'h0A, 8'h0D, 8'h09, 8'h3A, 8'h3B, 8'h3D, 8'h25: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [ORG_W-1:0] f_clamp(input logic [POS_W-1:0] x);
		logic [ORG_W-1:0] r;
		if (x > POS_W'(MAX_LEN - 1))
			r = ORG_W'(MAX_LEN - 1);
		else
			r = x[ORG_W-1:0];
		return r;
	endfunction

	function automatic walk_t f_emit(input walk_t w, input logic [ORG_W-1:0] st,
			input logic [POS_W-1:0] ln);
		walk_t r;
		r = w;
		if (w.cnt < CNT_W'(MAX_RES)) begin
			r.start[w.cnt[RES_IDX_W-1:0]] = st;
			r.len[w.cnt[RES_IDX_W-1:0]]   = ln;
			r.cnt = w.cnt + CNT_W'(1);
		end
		return r;
	endfunction

	function automatic walk_t f_close(input walk_t w, input logic [POS_W-1:0] e);
		walk_t r;
		logic [POS_W-1:0] ln;
		ln = (e > POS_W'(w.origin)) ? (e - POS_W'(w.origin)) : '0;
		r = f_emit(w, w.origin, ln);
		r.origin = f_clamp(e);
		r.mode = MODE_IDLE;
		return r;
	endfunction

	// classification of a byte from idle or prefix
	function automatic walk_t f_dispatch(input walk_t w, input logic [BYTE_W-1:0] c,
			input logic [ORG_W-1:0] p);
		walk_t r;
		r = w;
		if (w.mode == MODE_IDLE)
			r.origin = p;
		if (c == CH_APOS) begin
			r.mode = MODE_APOS;
		end else if (f_is_letter(c)) begin
			r.mode = MODE_LETTER;
		end else if (f_is_digit(c) || f_is_punct(c)) begin
			if (w.mode == MODE_PREFIX && w.ois) begin
				r = f_emit(r, r.origin, POS_W'(1));
				r.origin = f_clamp(POS_W'(r.origin) + POS_W'(1));
			end
			if (f_is_digit(c)) begin
				if (POS_W'(p) == POS_W'(r.origin) + POS_W'(DIGIT_CHUNK)) begin
					r = f_emit(r, r.origin, POS_W'(DIGIT_CHUNK));
					r.origin = p;
				end
				r.mode = MODE_DIGIT;
			end else begin
				r.mode = MODE_PUNCT;
			end
		end else begin
			if (w.mode == MODE_IDLE)
				r.ois = (c == CH_SPACE);
			r.mode = MODE_PREFIX;
		end
		return r;
	endfunction

	// one byte against every mode but the apostrophe pair
	function automatic walk_t f_feed(input walk_t w, input logic [BYTE_W-1:0] c,
			input logic [ORG_W-1:0] p, input logic [POS_W-1:0] eb,
			input logic [POS_W-1:0] ea);
		walk_t r;
		r = w;
		case (w.mode)
			MODE_LETTER: begin
				if (!f_is_letter(c)) begin
					r = f_close(r, eb);
					r = f_dispatch(r, c, p);
				end
			end
			MODE_PUNCT: begin
				if (!f_is_punct(c)) begin
					r = f_close(r, eb);
					r = f_dispatch(r, c, p);
				end
			end
			MODE_DIGIT: begin
				if (f_is_digit(c)) begin
					if (POS_W'(p) == POS_W'(r.origin) + POS_W'(DIGIT_CHUNK)) begin
						r = f_emit(r, r.origin, POS_W'(DIGIT_CHUNK));
						r.origin = p;
					end
				end else begin
					r = f_close(r, eb);
					r = f_dispatch(r, c, p);
				end
			end
			MODE_APOS: begin
				if (c == CH_S || c == CH_T || c == CH_M || c == CH_D) begin
					r = f_close(r, ea);
				end else if (c == CH_R || c == CH_V || c == CH_L) begin
					r.held = c;
					r.mode = MODE_APOS2;
				end else begin
					r = f_close(r, eb);
					r = f_dispatch(r, c, p);
				end
			end
			default: begin
				r = f_dispatch(r, c, p);
			end
		endcase
		return r;
	endfunction

	// full handling of one byte, apostrophe pair included
	function automatic walk_t f_step(input walk_t w, input logic [BYTE_W-1:0] c,
			input logic [ORG_W-1:0] p, input logic [POS_W-1:0] eb,
			input logic [POS_W-1:0] ea, input logic [POS_W-1:0] he);
		walk_t r;
		r = w;
		if (w.mode == MODE_APOS2) begin
			if ((c == CH_E && (w.held == CH_R || w.held == CH_V)) ||
					(c == CH_L && w.held == CH_L)) begin
				r = f_close(r, ea);
			end else begin
				// pair broken: apostrophe closes, held letter opens a letter run
				r = f_close(r, he);
				r = f_dispatch(r, w.held, f_clamp(he));
				r = f_feed(r, c, p, eb, ea);
			end
		end else begin
			r = f_feed(r, c, p, eb, ea);
		end
		return r;
	endfunction

endpackage

// ===== rtl/pts_front.sv =====
// front end: classifies each byte, keeps run state and builds the span record
module pts_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      byte_valid,
	output logic                      byte_stall,
	input  logic [pts_pkg::BYTE_W-1:0] text_byte,
	input  logic                      final_byte,
	input  logic                      q_full,
	output logic                      q_push,
	output pts_pkg::rec_t             q_rec
);
	import pts_pkg::*;

	logic [POS_W-1:0]  byte_pos_q;
	logic [ORG_W-1:0]  origin_q;
	mode_t             mode_q;
	logic              ois_q;
	logic [BYTE_W-1:0] held_q;
	logic              ovf_q;

	logic              accept;
	logic              at_limit;
	logic              ovf_new;
	logic [POS_W-1:0]  qs;
	logic [ORG_W-1:0]  p;
	logic [POS_W-1:0]  eb;
	logic [POS_W-1:0]  ea;
	logic [POS_W-1:0]  he;
	walk_t             w_in;
	walk_t             w_mid;
	walk_t             w_out;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;

	always_comb begin
		at_limit = (byte_pos_q >= POS_W'(MAX_LEN));
		ovf_new  = ovf_q || at_limit;
		qs       = at_limit ? POS_W'(MAX_LEN) : byte_pos_q;
		p        = f_clamp(qs);
		eb       = qs;
		ea       = (qs >= POS_W'(MAX_LEN)) ? POS_W'(MAX_LEN) : qs + POS_W'(1);
		if (byte_pos_q == '0)
			he = '0;
		else if (ovf_q)
			he = POS_W'(MAX_LEN);
		else
			he = byte_pos_q - POS_W'(1);

		w_in        = '0;
		w_in.mode   = mode_q;
		w_in.origin = origin_q;
		w_in.ois    = ois_q;
		w_in.held   = held_q;

		w_mid = f_step(w_in, text_byte, p, eb, ea, he);

		// flush of the open run on the last byte, with an empty span if none came out
		w_out = w_mid;
		if (final_byte) begin
			case (w_mid.mode)
				MODE_LETTER, MODE_DIGIT, MODE_PUNCT, MODE_APOS: begin
					w_out = f_close(w_mid, ea);
				end
				MODE_APOS2: begin
					w_out = f_close(w_mid, eb);
					w_out = f_close(w_out, ea);
				end
				default: begin
					w_out = w_mid;
				end
			endcase
			if (w_out.cnt == '0)
				w_out = f_emit(w_out, w_out.origin, '0);
		end

		q_rec.start    = w_out.start;
		q_rec.len      = w_out.len;
		q_rec.last_idx = RES_IDX_W'(w_out.cnt - CNT_W'(1));
		q_rec.is_last  = final_byte;
		q_rec.overflow = ovf_new;
		q_push         = accept && (w_out.cnt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			origin_q   <= '0;
			mode_q     <= MODE_IDLE;
			ois_q      <= 1'b0;
			held_q     <= '0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			if (final_byte) begin
				byte_pos_q <= '0;
				origin_q   <= '0;
				mode_q     <= MODE_IDLE;
				ois_q      <= 1'b0;
				held_q     <= '0;
				ovf_q      <= 1'b0;
			end else begin
				byte_pos_q <= ea;
				origin_q   <= w_out.origin;
				mode_q     <= w_out.mode;
				ois_q      <= w_out.ois;
				held_q     <= w_out.held;
				ovf_q      <= ovf_new;
			end
		end
	end

`ifndef SYNTHESIS
	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && final_byte |=> byte_pos_q == '0 && mode_q == MODE_IDLE)
		else $error("state not cleared after final byte");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= POS_W'(MAX_LEN))
		else $error("byte position beyond limit");
	a_final_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && final_byte |-> q_push)
		else $error("final byte produced no span record");
`endif

endmodule

// ===== rtl/pts_queue.sv =====
// short record queue between the classifying front and the span back end
module pts_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pts_pkg::rec_t push_rec,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output pts_pkg::rec_t head_rec
);
	import pts_pkg::*;

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign head_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

// ===== rtl/pts_back.sv =====
// back end: walks the spans of each queued record out through the output register
module pts_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  pts_pkg::rec_t                     head_rec,
	output logic                              q_pop,
	output logic                              span_valid,
	input  logic                              span_stall,
	output logic [pts_pkg::SPAN_START_W-1:0]  span_start,
	output logic [pts_pkg::SPAN_LENGTH_W-1:0] span_length,
	output logic                              final_span,
	output logic                              length_overflow
);
	import pts_pkg::*;

	logic [RES_IDX_W-1:0]     idx_q;
	logic                     valid_q;
	logic [SPAN_START_W-1:0]  start_q;
	logic [SPAN_LENGTH_W-1:0] length_q;
	logic                     final_q;
	logic                     ovf_q;
	logic                     take;
	logic                     at_end;

	assign take   = !q_empty && (!valid_q || !span_stall);
	assign at_end = (idx_q == head_rec.last_idx);
	assign q_pop  = take && at_end;

	assign span_valid      = valid_q;
	assign span_start      = start_q;
	assign span_length     = length_q;
	assign final_span      = final_q;
	assign length_overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q   <= at_end ? '0 : idx_q + RES_IDX_W'(1);
		end else if (!span_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			start_q  <= SPAN_START_W'(head_rec.start[idx_q]);
			length_q <= SPAN_LENGTH_W'(head_rec.len[idx_q]);
			final_q  <= head_rec.is_last && at_end;
			ovf_q    <= head_rec.overflow;
		end
	end

endmodule

// ===== rtl/pretokenizer_word_splitter.sv =====
// top level of the pretokenizer word splitter: byte stream in, token spans out
//
//  channel | handshake             | payload                                   | per word
//  --------+-----------------------+-------------------------------------------+----------
//  byte    | byte_valid/byte_stall | text_byte, final_byte                     | one byte
//  span    | span_valid/span_stall | span_start, span_length, final_span,      | one span
//          |                       | length_overflow                           |
//
// a byte is classified in the cycle it is accepted, one byte per cycle unless stalled
// each byte yields zero to four spans; the back end sends one span per cycle
// unless stalled, so the span port bounds throughput on bytes that close several tokens
// first span of a byte goes through the record queue, then into the output register
// arst_n clears run state, queue pointers and output valid; no clearing pass
// byte_stall rises only while the four-record queue is full
module pretokenizer_word_splitter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [pts_pkg::BYTE_W-1:0]        text_byte,
	input  logic                              final_byte,
	output logic                              span_valid,
	input  logic                              span_stall,
	output logic [pts_pkg::SPAN_START_W-1:0]  span_start,
	output logic [pts_pkg::SPAN_LENGTH_W-1:0] span_length,
	output logic                              final_span,
	output logic                              length_overflow
);
	import pts_pkg::*;

	// record hand-off between front and queue
	logic  q_push;
	rec_t  q_in_rec;
	logic  q_full;

	// record hand-off between queue and back end
	logic  q_pop;
	logic  q_empty;
	rec_t  q_head_rec;

	// front: run classification, saturating positions, digit chunking,
	// apostrophe lookahead and final flush all settle within the accept cycle
	pts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_rec      (q_in_rec)
	);

	// queue decouples byte intake from span delivery
	pts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_in_rec),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_rec (q_head_rec)
	);

	// back: serialises each record's spans onto the output register
	pts_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.head_rec        (q_head_rec),
		.q_pop           (q_pop),
		.span_valid      (span_valid),
		.span_stall      (span_stall),
		.span_start      (span_start),
		.span_length     (span_length),
		.final_span      (final_span),
		.length_overflow (length_overflow)
	);

endmodule

// ===== test/span_check_pkg.sv =====
// span predictor and scoreboard for the word splitter testbench
package span_check_pkg;
	import pts_pkg::*;

	typedef struct {
		logic [SPAN_START_W-1:0]  start;
		logic [SPAN_LENGTH_W-1:0] length;
		logic                     fin;
		logic                     ovf;
	} span_t;

	class span_scoreboard;
		span_t expected_spans[$];
		span_t byte_spans[$];
		int unsigned pos;
		int unsigned origin;
		mode_t mode;
		bit lead_space;
		logic [BYTE_W-1:0] held;
		bit ovf;
		int unsigned errors;
		int unsigned spans_checked;
		int unsigned prompts_seen;
		int unsigned overflow_prompts;

		function new();
			clear_run();
		endfunction

		function void clear_run();
			pos = 0;
			origin = 0;
			mode = MODE_IDLE;
			lead_space = 1'b0;
			held = '0;
			ovf = 1'b0;
		endfunction

		static function bit is_alpha(logic [BYTE_W-1:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		static function bit is_num(logic [BYTE_W-1:0] c);
			return c >= "0" && c <= "9";
		endfunction

		// ! . , ? / \ * - # lf cr tab : ; = %
		static function bit is_sep(logic [BYTE_W-1:0] c);
			case (c)
				8'h21, 8'h2E, 8'h2C, 8'h3F, 8'h2F, 8'h5C, 8'h2A, 8'h2D,
				8'h23, 8'h0A, 8'h0D, 8'h09, 8'h3A, 8'h3B, 8'h3D, 8'h25: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		static function int unsigned clamp(int unsigned x);
			return (x > MAX_LEN - 1) ? MAX_LEN - 1 : x;
		endfunction

		function void emit(int unsigned st, int unsigned ln);
			span_t s;
			if (byte_spans.size() < MAX_RES) begin
				s.start = SPAN_START_W'(st);
				s.length = SPAN_LENGTH_W'(ln);
				s.fin = 1'b0;
				s.ovf = ovf;
				byte_spans.insert(byte_spans.size(), s);
			end
		endfunction

		function void close_run(int unsigned e);
			emit(origin, (e > origin) ? e - origin : 0);
			origin = clamp(e);
			mode = MODE_IDLE;
		endfunction

		// classify a byte when no run is open or only a prefix is held
		function void open_run(logic [BYTE_W-1:0] c, int unsigned p);
			if (mode == MODE_IDLE)
				origin = p;
			if (c == CH_APOS) begin
				mode = MODE_APOS;
			end else if (is_alpha(c)) begin
				mode = MODE_LETTER;
			end else if (is_num(c) || is_sep(c)) begin
				if (mode == MODE_PREFIX && lead_space) begin
					emit(origin, 1);
					origin = clamp(origin + 1);
				end
				if (is_num(c)) begin
					if (p >= origin && p - origin == DIGIT_CHUNK) begin
						emit(origin, DIGIT_CHUNK);
						origin = p;
					end
					mode = MODE_DIGIT;
				end else begin
					mode = MODE_PUNCT;
				end
			end else begin
				if (mode == MODE_IDLE)
					lead_space = (c == CH_SPACE);
				mode = MODE_PREFIX;
			end
		endfunction

		function void take_byte(logic [BYTE_W-1:0] c, int unsigned p, int unsigned eb,
				int unsigned ea);
			case (mode)
				MODE_LETTER: begin
					if (!is_alpha(c)) begin
						close_run(eb);
						open_run(c, p);
					end
				end
				MODE_PUNCT: begin
					if (!is_sep(c)) begin
						close_run(eb);
						open_run(c, p);
					end
				end
				MODE_DIGIT: begin
					if (is_num(c)) begin
						if (p >= origin && p - origin == DIGIT_CHUNK) begin
							emit(origin, DIGIT_CHUNK);
							origin = p;
						end
					end else begin
						close_run(eb);
						open_run(c, p);
					end
				end
				MODE_APOS: begin
					if (c == CH_S || c == CH_T || c == CH_M || c == CH_D) begin
						close_run(ea);
					end else if (c == CH_R || c == CH_V || c == CH_L) begin
						held = c;
						mode = MODE_APOS2;
					end else begin
						close_run(eb);
						open_run(c, p);
					end
				end
				default: begin
					open_run(c, p);
				end
			endcase
		endfunction

		// an accepted byte: work out the spans it releases
		function void note_byte(logic [BYTE_W-1:0] c, bit last);
			int unsigned q, p, eb, ea, he;
			bit ovf_prev;
			int k;
			byte_spans.delete();
			q = pos;
			ovf_prev = ovf;
			if (q >= MAX_LEN) begin
				q = MAX_LEN;
				ovf = 1'b1;
			end
			p = clamp(q);
			eb = q;
			ea = (q + 1 > MAX_LEN) ? MAX_LEN : q + 1;
			he = (q == 0) ? 0 : (ovf_prev ? MAX_LEN : q - 1);
			pos = ea;
			if (mode == MODE_APOS2) begin
				if ((c == CH_E && (held == CH_R || held == CH_V)) ||
						(c == CH_L && held == CH_L)) begin
					close_run(ea);
				end else begin
					close_run(he);
					open_run(held, clamp(he));
					take_byte(c, p, eb, ea);
				end
			end else begin
				take_byte(c, p, eb, ea);
			end
			if (last) begin
				case (mode)
					MODE_LETTER, MODE_DIGIT, MODE_PUNCT, MODE_APOS: close_run(ea);
					MODE_APOS2: begin
						close_run(eb);
						close_run(ea);
					end
					default: ;
				endcase
				if (byte_spans.size() == 0)
					emit(origin, 0);
				k = byte_spans.size() - 1;
				byte_spans[k].fin = 1'b1;
				prompts_seen++;
				if (ovf)
					overflow_prompts++;
				clear_run();
			end
			foreach (byte_spans[i])
				expected_spans.insert(expected_spans.size(), byte_spans[i]);
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] got,
				longint unsigned stamp);
			if (got !== want) begin
				errors++;
				$display("%0d ns: %s expected %0d got %0d", stamp, field, want, got);
			end
		endfunction

		// an accepted span against the oldest expectation
		function void check_span(logic [SPAN_START_W-1:0] st, logic [SPAN_LENGTH_W-1:0] ln,
				logic fin, logic of, longint unsigned stamp);
			span_t want;
			if (expected_spans.size() == 0) begin
				errors++;
				$display("%0d ns: span start %0d length %0d with none expected",
					stamp, st, ln);
				return;
			end
			want = expected_spans.pop_front();
			spans_checked++;
			compare_field("span_start", 16'(want.start), 16'(st), stamp);
			compare_field("span_length", 16'(want.length), 16'(ln), stamp);
			compare_field("final_span", 16'(want.fin), 16'(fin), stamp);
			compare_field("length_overflow", 16'(want.ovf), 16'(of), stamp);
		endfunction
	endclass

endpackage

// ===== test/tb_top.sv =====
// top level testbench of the word splitter: stimulus, span sink and watchdog
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pts_pkg::*;
	import span_check_pkg::*;

	typedef logic [BYTE_W-1:0] text_q_t[$];

	localparam int RESET_CYCLES    = 10;
	localparam int RANDOM_BYTES    = 330;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int HOLD_OFF_AFTER  = 60;
	// well above the hold-off and the longest random gap
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 16;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     byte_valid = 1'b0;
	logic                     byte_stall;
	logic [BYTE_W-1:0]        text_byte = '0;
	logic                     final_byte = 1'b0;
	logic                     span_valid;
	logic                     span_stall = 1'b0;
	logic [SPAN_START_W-1:0]  span_start;
	logic [SPAN_LENGTH_W-1:0] span_length;
	logic                     final_span;
	logic                     length_overflow;

	span_scoreboard sb = new();

	// burst: neither side idles; hold_off_req asks the sink for one long stall
	bit          burst = 1'b0;
	bit          hold_off_req = 1'b0;
	int unsigned bytes_sent = 0;
	int unsigned input_stall_cycles = 0;
	int unsigned hold_offs_done = 0;

	// byte classes used to build prompts
	string       separators = "!.,?/\\*-#\n\r\t:;=%";
	string       apos_tails[14] = '{"s", "t", "m", "d", "re", "ve", "ll",
		"r", "v", "l", "rx", "lz", "q", "e"};
	logic [7:0]  loose_bytes[8] = '{8'h20, 8'h22, 8'h28, 8'h24, 8'h26, 8'h2B, 8'h40, 8'h7E};

	pretokenizer_word_splitter uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.text_byte       (text_byte),
		.final_byte      (final_byte),
		.span_valid      (span_valid),
		.span_stall      (span_stall),
		.span_start      (span_start),
		.span_length     (span_length),
		.final_span      (final_span),
		.length_overflow (length_overflow)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	// append one byte to a prompt
	function automatic void put_byte(ref text_q_t q, input logic [BYTE_W-1:0] b);
		q.insert(q.size(), b);
	endfunction

	function automatic void add_text(ref text_q_t q, input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(q, s[i]);
	endfunction

	// one token-like piece of text, mostly well formed, some noise
	function automatic void add_token(ref text_q_t q);
		int unsigned kind, n;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				if ($urandom_range(0, 1))
					put_byte(q, 8'h41 + 8'($urandom_range(0, 25)));
				else
					put_byte(q, 8'h61 + 8'($urandom_range(0, 25)));
			end
		end else if (kind < 45) begin
			put_byte(q, CH_SPACE);
		end else if (kind < 57) begin
			n = $urandom_range(1, 8);
			repeat (n)
				put_byte(q, 8'h30 + 8'($urandom_range(0, 9)));
		end else if (kind < 67) begin
			n = $urandom_range(1, 3);
			repeat (n)
				put_byte(q, separators[$urandom_range(0, 15)]);
		end else if (kind < 80) begin
			// apostrophe with a suffix, a partial pair, a broken one or no suffix
			put_byte(q, CH_APOS);
			add_text(q, apos_tails[$urandom_range(0, 13)]);
		end else if (kind < 90) begin
			if ($urandom_range(0, 2) == 0)
				put_byte(q, 8'h80 + 8'($urandom_range(0, 127)));
			else
				put_byte(q, loose_bytes[$urandom_range(0, 7)]);
		end else begin
			put_byte(q, 8'($urandom_range(0, 255)));
		end
	endfunction

	// offer one byte word and hold it until taken, then maybe idle
	task automatic send_byte(input logic [BYTE_W-1:0] c, input bit last);
		int unsigned gap;
		byte_valid <= 1'b1;
		text_byte <= c;
		final_byte <= last;
		@(posedge clk);
		while (byte_stall) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		sb.note_byte(c, last);
		bytes_sent++;
		gap = burst ? 0 : pick_idle();
		// valid is only lowered when a gap follows, never dropped and raised in one step
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_prompt(input text_q_t text);
		for (int i = 0; i < text.size(); i++)
			send_byte(text[i], i == text.size() - 1);
	endtask

	// span sink: takes a word when valid is high and stall was low at the edge
	initial begin : span_sink
		int unsigned left;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (span_valid && !span_stall)
				sb.check_span(span_start, span_length, final_span, length_overflow, $time);
			if (left > 0) begin
				left--;
			end else if (hold_off_req) begin
				// long hold-off so the queue fills and the byte side stalls
				left = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
				hold_offs_done++;
			end else if (!burst) begin
				left = pick_idle();
			end
			span_stall <= (left > 0);
		end
	end

	// watchdog: too long without any word taken on either side
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (byte_valid && !byte_stall) || (span_valid && !span_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0d ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		text_q_t q;
		int unsigned bytes_random;
		int unsigned target;
		bit hold_requested;
		bytes_random = 0;
		hold_requested = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed prompts
		// lone zero byte: nothing classified, so only the empty marker comes out
		q = {};
		put_byte(q, 8'h00);
		send_prompt(q);
		// top byte value as a prefix of a letter
		q = {};
		put_byte(q, 8'hFF);
		add_text(q, "Z");
		send_prompt(q);
		// leading space split off before digits, digits cut in threes
		q = {};
		add_text(q, " 1234");
		send_prompt(q);
		// apostrophe with a two-letter suffix
		q = {};
		add_text(q, "we're");
		send_prompt(q);
		// broken pair: the held letter opens a letter run
		q = {};
		add_text(q, "'lx");
		send_prompt(q);
		// prompt ends while a pair is half seen
		q = {};
		add_text(q, "a'v");
		send_prompt(q);
		// apostrophe with no suffix stands alone
		q = {};
		add_text(q, "'q");
		send_prompt(q);
		// leading space split off before punctuation
		q = {};
		add_text(q, " =%");
		send_prompt(q);

		// mixed pairs, chunks and punctuation sent back to back
		burst = 1'b1;
		q = {};
		add_text(q, "ab'lx 12'r9 ,.'vz it's 9999 'l!");
		send_prompt(q);
		burst = 1'b0;

		// random prompts, some of them bursts
		while (bytes_random < RANDOM_BYTES) begin
			q = {};
			target = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 20);
			while (q.size() < target)
				add_token(q);
			burst = ($urandom_range(0, 4) == 0);
			send_prompt(q);
			bytes_random += q.size();
			if (!hold_requested && bytes_random >= HOLD_OFF_AFTER) begin
				hold_off_req = 1'b1;
				hold_requested = 1'b1;
			end
		end
		burst = 1'b0;
		byte_valid <= 1'b0;

		// drain, then give the block time to show any stray span
		while (sb.expected_spans.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d bytes in %0d prompts (%0d past the length limit), %0d spans checked",
			bytes_sent, sb.prompts_seen, sb.overflow_prompts, sb.spans_checked);
		$display("run: byte side stalled %0d cycles, %0d long span hold-off(s)",
			input_stall_cycles, hold_offs_done);
		if (sb.errors == 0 && sb.expected_spans.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
